// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared codes and types for the double-ended list with search.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_SEARCH    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // one result request
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   length;
  } res_t;

endpackage

// File: sv/double_ended_list_with_search_core.sv
// ----------------------------------------------------------------------------
// double_ended_list_with_search_core
// Double-ended list of signed 32-bit values in a DEPTH-entry ring store,
// with add/remove at both ends and a linear search from the front.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | input     | in_valid/in_stall  | in_op, in_value
//  out_    | output    | out_valid/out_stall| out_status, out_position,
//          |           |                    | out_length
//
//  Add/remove request: result registered in the sequencer on accept, then
//  moved to the output register once that register can take it.
//  Search request: walks the stored entries from the front, one registered
//  store read plus compare per entry (through the shared ring index unit),
//  over at most the live count, up to DEPTH entries; stops on the first match.
//  One request at a time: in_stall is high during reset and from accept
//  until its result leaves the sequencer for the output register.
//  Reset (rst_n low, synchronous) empties the list; store contents are left.
//  out_stall holds the output register; a new request may still be taken
//  while a finished result waits there.
//
module double_ended_list_with_search_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic [LEN_W-1:0]           out_length
);

  localparam int PW = $clog2(DEPTH);

  logic                  busy;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [PW-1:0]         rd_addr;
  logic [VALUE_W-1:0]    rd_data_r;
  logic                  res_valid;
  res_t                  res;
  logic                  res_take;
  logic                  out_valid_r;
  res_t                  out_r;

  // ring store: one write port, one registered read port
  logic [VALUE_W-1:0]    mem [DEPTH];

  deq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_op    (in_op),
    .req_value (in_value),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data_r),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // write happens on the accept edge, so in_value is the store data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // no request is taken while reset is held
  assign in_stall = busy || !rst_n;

  // output register parts the sequencer from the result channel
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_position = out_r.position;
  assign out_length   = out_r.length;

`ifndef SYNTH
  a_pos_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_position == '0))
    else $error("position reported without a match");
  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_length == LEN_W'(DEPTH)))
    else $error("full status with list not full");
  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_length == '0))
    else $error("empty status with entries held");
`endif

endmodule

// File: sv/deq_ring_add.sv
// ----------------------------------------------------------------------------
// deq_ring_add
// Shared ring index unit: (base + offset) mod DEPTH, one add and one compare.
// ----------------------------------------------------------------------------
module deq_ring_add #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0]   base,
  input  logic [$clog2(DEPTH+1)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0]   slot
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = PW + 1;

  logic [SW-1:0] sum;

  // base < DEPTH and offset <= DEPTH keep the sum below 2*DEPTH
  assign sum  = SW'(base) + SW'(offset);
  assign slot = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);

endmodule

// File: sv/deq_seq.sv
// ----------------------------------------------------------------------------
// deq_seq
// Sequencer: front pointer, entry count, store commands and the search walk.
// ----------------------------------------------------------------------------
module deq_seq
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  input  logic [OP_W-1:0]             req_op,
  input  logic [VALUE_W-1:0]          req_value,
  output logic                        busy,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [$clog2(DEPTH)-1:0]    rd_addr,
  input  logic [VALUE_W-1:0]          rd_data,
  output logic                        res_valid,
  output res_t                        res,
  input  logic                        res_take
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [PW-1:0]        front_r, front_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        rd_slot_r, rd_slot_nxt;
  logic [PW-1:0]        off_r, off_nxt;
  logic [VALUE_W-1:0]   key_r, key_nxt;
  res_t                 res_r, res_nxt;

  logic [PW-1:0]        ring_base;
  logic [CW-1:0]        ring_off;
  logic [PW-1:0]        ring_slot;
  logic                 take;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        pos_w;
  op_t                  op;

  deq_ring_add #(.DEPTH(DEPTH)) u_ring (
    .base   (ring_base),
    .offset (ring_off),
    .slot   (ring_slot)
  );

  assign op    = op_t'(req_op);
  assign take  = req_valid && (state_r == S_IDLE);
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign pos_w = CW'(off_r) + CW'(1);

  // operand select for the shared ring unit
  always_comb begin
    ring_base = front_r;
    ring_off  = CW'(1);
    if (state_r == S_SCAN) begin
      ring_base = rd_slot_r;
      ring_off  = CW'(1);
    end else begin
      case (op)
        OP_ADD_FRONT: ring_off = CW'(DEPTH - 1);
        OP_ADD_BACK:  ring_off = count_r;
        default:      ring_off = CW'(1);
      endcase
    end
  end

  assign rd_addr = (state_r == S_SCAN) ? ring_slot : front_r;
  assign wr_addr = ring_slot;

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    rd_slot_nxt = rd_slot_r;
    off_nxt     = off_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    wr_en       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt        = S_DONE;
          res_nxt.status   = ST_OK;
          res_nxt.position = '0;
          unique case (op)
            OP_ADD_FRONT: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                front_nxt = ring_slot;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_ADD_BACK: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REM_FRONT: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                front_nxt = ring_slot;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_REM_BACK: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt   = S_SCAN;
                rd_slot_nxt = front_r;
                off_nxt     = '0;
                key_nxt     = req_value;
              end
            end
            default: ;
          endcase
          res_nxt.length = LEN_W'(count_nxt);
        end
      end
      S_SCAN: begin
        if (rd_data == key_r) begin
          state_nxt        = S_DONE;
          res_nxt.status   = ST_OK;
          res_nxt.position = POS_W'(pos_w);
        end else if (pos_w == count_r) begin
          state_nxt        = S_DONE;
          res_nxt.status   = ST_MISS;
          res_nxt.position = '0;
        end else begin
          rd_slot_nxt = ring_slot;
          off_nxt     = off_r + PW'(1);
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    off_r     <= off_nxt;
    key_r     <= key_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");
  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < PW'(DEPTH - 1) || front_r == PW'(DEPTH - 1))
    else $error("front pointer outside store");
  a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0 && CW'(off_r) < count_r))
    else $error("search walked past the live entries");
`endif

endmodule
